// ===== src/rcst_pkg.sv =====
// shared types, codes and reset constants for the race countdown stopwatch timer
// no dependencies
package rcst_pkg;

	typedef enum logic [3:0] {
		OP_TICK    = 4'd0,
		OP_START   = 4'd1,
		OP_STOP    = 4'd2,
		OP_RESET   = 4'd3,
		OP_LAP     = 4'd4,
		OP_MODE    = 4'd5,
		OP_EVENT   = 4'd6,
		OP_ELAPSED = 4'd7,
		OP_PRESET  = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		MODE_STOPWATCH = 2'd0,
		MODE_RACE      = 2'd1,
		MODE_PRESET    = 2'd2,
		MODE_WATCH     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_MINOR = 2'd1,
		EV_MAJOR = 2'd2
	} ev_t;

	typedef enum logic [1:0] {
		CFG_START_GUN = 2'd0,
		CFG_PREP      = 2'd1,
		CFG_ONE_MIN   = 2'd2,
		CFG_LAP_SW    = 2'd3
	} cfg_idx_t;

	localparam int unsigned CFG_W = 20;

	localparam logic [CFG_W-1:0] START_GUN_RST = 20'd3000;
	localparam logic [CFG_W-1:0] PREP_RST      = 20'd2400;
	localparam logic [CFG_W-1:0] ONE_MIN_RST   = 20'd600;
	localparam logic [CFG_W-1:0] LAP_SW_RST    = 20'd1200;

	typedef struct packed {
		logic [CFG_W-1:0] start_gun;
		logic [CFG_W-1:0] prep;
		logic [CFG_W-1:0] one_min;
		logic [CFG_W-1:0] lap_switch;
	} cfg_t;

	typedef struct packed {
		logic [31:0] elapsed;
		logic        running;
		logic [39:0] origin;
		logic [39:0] last_wall;
		logic [31:0] target;
		logic [31:0] preset;
		mode_t       mode;
		logic [31:0] last_lap;
		logic [31:0] last_signal;
	} st_t;

	// start gun minus a signal time, sign extended
	function automatic logic signed [32:0] cfg_gap(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b);
		logic signed [CFG_W:0] d;
		d = $signed({1'b0, a}) - $signed({1'b0, b});
		return {{(33-CFG_W-1){d[CFG_W]}}, d};
	endfunction

endpackage

// ===== src/race_countdown_stopwatch_timer.sv =====
// race countdown stopwatch timer top level: input register, state update, result register
// depends on rcst_pkg and rcst_event
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid in_ready opcode tick_ms wall_time      | in
//          | new_mode value                                 |
//  out     | out_valid out_ready time_shown event_res        | out
//          | lap_time running mode_now fast_tick            |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data         | in
//
// a command transfers into the input register; once the result register is free or being
// drained, the command updates the timer state and loads the result register
// one command per cycle sustained while out_ready stays high; the state update is
// combinational, so commands follow back to back
// the input register stalls only while it holds a command and the result register is full
// reset returns the configuration and state to their reset values; cfg_ready is always high
module race_countdown_stopwatch_timer import rcst_pkg::*; #(
	parameter int unsigned UNITS_PER_SECOND = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3:0]           opcode,
	input  logic [15:0]          tick_ms,
	input  logic [39:0]          wall_time,
	input  logic [1:0]           new_mode,
	input  logic signed [32:0]   value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [32:0]   time_shown,
	output logic [1:0]           event_res,
	output logic signed [32:0]   lap_time,
	output logic                 running,
	output logic [1:0]           mode_now,
	output logic                 fast_tick,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int unsigned TICK_DIV_RAW = 1000 / UNITS_PER_SECOND;
	localparam int unsigned TICK_DIV = (TICK_DIV_RAW == 0) ? 1 : TICK_DIV_RAW;
	localparam int unsigned TICK_SH = $clog2(TICK_DIV);
	localparam logic [63:0] TICK_M =
		((64'd1 << (16 + TICK_SH)) + 64'(TICK_DIV) - 64'd1) / 64'(TICK_DIV);
	localparam logic [31:0] U32      = 32'(UNITS_PER_SECOND);
	localparam logic [31:0] FAST_LIM = 32'(3600 * UNITS_PER_SECOND);
	localparam logic [31:0] PRESET_RST = 32'(600 * UNITS_PER_SECOND);

	logic                valid_s1;
	logic [3:0]          opcode_s1;
	logic [15:0]         tick_ms_s1;
	logic [39:0]         wall_time_s1;
	logic [1:0]          new_mode_s1;
	logic signed [32:0]  value_s1;

	st_t  st_q;
	st_t  st_n;
	cfg_t cfg_q;

	logic                out_valid_q;
	logic signed [32:0]  display_q;
	logic [1:0]          event_q;
	logic signed [32:0]  lap_q;
	logic                running_q;
	logic [1:0]          mode_q;
	logic                fast_q;

	logic                proc;
	logic signed [32:0]  disp_cur;
	logic signed [32:0]  disp_nxt;
	ev_t                 ev_chk;
	ev_t                 ev_out;
	logic signed [32:0]  lap_v;
	logic                se_req;
	logic signed [32:0]  se_val;
	logic [33:0]         tick_prod;
	logic [15:0]         tick_q;
	logic [39:0]         lw_eff;
	logic [31:0]         e_tick;
	logic [39:0]         wall_m_origin;
	logic [32:0]         sig_sum;

	assign proc      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || proc;
	assign cfg_ready = 1'b1;

	assign disp_cur = (st_q.mode == MODE_STOPWATCH) ? $signed({1'b0, st_q.elapsed})
		: $signed({1'b0, st_q.target}) - $signed({1'b0, st_q.elapsed});
	assign disp_nxt = (st_n.mode == MODE_STOPWATCH) ? $signed({1'b0, st_n.elapsed})
		: $signed({1'b0, st_n.target}) - $signed({1'b0, st_n.elapsed});

	rcst_event #(
		.UNITS_PER_SECOND(UNITS_PER_SECOND)
	) u_event (
		.st  (st_q),
		.cfg (cfg_q),
		.disp(disp_cur),
		.ev  (ev_chk)
	);

	// tick length to units by exact reciprocal
	assign tick_prod = {18'd0, tick_ms_s1} * {16'd0, TICK_M[17:0]};
	assign tick_q    = 16'(tick_prod >> (16 + TICK_SH));

	assign lw_eff        = (st_q.last_wall == 40'd0) ? wall_time_s1 : st_q.last_wall;
	assign e_tick        = st_q.elapsed + {16'd0, tick_q};
	assign wall_m_origin = wall_time_s1 - st_q.origin;
	assign sig_sum       = {1'b0, st_q.elapsed} + {1'b0, U32};

	always_comb begin
		st_n   = st_q;
		ev_out = EV_NONE;
		lap_v  = '0;
		se_req = 1'b0;
		se_val = '0;
		case (op_t'(opcode_s1))
			OP_TICK: begin
				if (st_q.running) begin
					st_n.elapsed = e_tick;
					if (wall_time_s1 > lw_eff) begin
						if (st_q.origin == 40'd0)
							st_n.origin = wall_time_s1 - {8'd0, e_tick};
						else
							st_n.elapsed = wall_m_origin[31:0];
					end
					st_n.last_wall = wall_time_s1;
				end
			end
			OP_START: begin
				st_n.running   = 1'b1;
				st_n.last_wall = '0;
				st_n.origin    = '0;
			end
			OP_STOP: begin
				st_n.running = 1'b0;
			end
			OP_RESET: begin
				se_req = 1'b1;
			end
			OP_LAP: begin
				case (st_q.mode)
					MODE_STOPWATCH: begin
						lap_v = $signed({1'b0, st_q.elapsed}) - $signed({1'b0, st_q.last_lap});
						st_n.last_lap = st_q.elapsed;
					end
					MODE_RACE, MODE_PRESET: begin
						lap_v = disp_cur;
						st_n.last_lap = st_q.elapsed;
						if (st_q.mode == MODE_RACE) begin
							se_req = 1'b1;
							if (disp_cur >= $signed({13'd0, cfg_q.lap_switch}))
								se_val = cfg_gap(cfg_q.start_gun, cfg_q.prep);
							else
								se_val = cfg_gap(cfg_q.start_gun, cfg_q.one_min);
						end
					end
					default: ;
				endcase
			end
			OP_MODE: begin
				st_n.mode = mode_t'(new_mode_s1);
				if (mode_t'(new_mode_s1) == MODE_RACE)
					st_n.target = {12'd0, cfg_q.start_gun};
				else if (mode_t'(new_mode_s1) == MODE_PRESET)
					st_n.target = st_q.preset;
			end
			OP_EVENT: begin
				ev_out = ev_chk;
				if (ev_chk != EV_NONE)
					st_n.last_signal = sig_sum[32] ? '1 : sig_sum[31:0];
			end
			OP_ELAPSED: begin
				se_req = 1'b1;
				se_val = value_s1;
			end
			OP_PRESET: begin
				if (!value_s1[32] && value_s1 != 33'sd0)
					st_n.preset = value_s1[31:0];
				if (st_q.mode == MODE_PRESET)
					st_n.target = st_n.preset;
				st_n.last_signal = '0;
			end
			default: ;
		endcase
		// set elapsed: negative ignored, nonzero ignored while stopped
		if (se_req && !se_val[32] && (st_q.running || se_val == 33'sd0)) begin
			st_n.elapsed     = se_val[31:0];
			st_n.last_signal = se_val[31:0];
			st_n.last_lap    = se_val[31:0];
			st_n.origin      = st_q.last_wall - {8'd0, se_val[31:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			cfg_q.start_gun  <= START_GUN_RST;
			cfg_q.prep       <= PREP_RST;
			cfg_q.one_min    <= ONE_MIN_RST;
			cfg_q.lap_switch <= LAP_SW_RST;
			st_q.elapsed     <= '0;
			st_q.running     <= 1'b0;
			st_q.origin      <= '0;
			st_q.last_wall   <= '0;
			st_q.target      <= {12'd0, START_GUN_RST};
			st_q.preset      <= PRESET_RST;
			st_q.mode        <= MODE_RACE;
			st_q.last_lap    <= '0;
			st_q.last_signal <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (proc)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (proc)
				st_q <= st_n;
			if (cfg_valid) begin
				case (cfg_idx_t'(cfg_index))
					CFG_START_GUN: cfg_q.start_gun  <= cfg_data;
					CFG_PREP:      cfg_q.prep       <= cfg_data;
					CFG_ONE_MIN:   cfg_q.one_min    <= cfg_data;
					CFG_LAP_SW:    cfg_q.lap_switch <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1    <= opcode;
			tick_ms_s1   <= tick_ms;
			wall_time_s1 <= wall_time;
			new_mode_s1  <= new_mode;
			value_s1     <= value;
		end
		if (proc) begin
			display_q <= disp_nxt;
			event_q   <= ev_out;
			lap_q     <= lap_v;
			running_q <= st_n.running;
			mode_q    <= st_n.mode;
			fast_q    <= st_n.running && (st_n.elapsed <= FAST_LIM);
		end
	end

	assign out_valid    = out_valid_q;
	assign time_shown   = display_q;
	assign event_res    = event_q;
	assign lap_time     = lap_q;
	assign running      = running_q;
	assign mode_now     = mode_q;
	assign fast_tick    = fast_q;

endmodule

// ===== src/rcst_event.sv =====
// event check: none, minor or major signal from the current timer state
// depends on rcst_pkg
module rcst_event import rcst_pkg::*; #(
	parameter int unsigned UNITS_PER_SECOND = 10
) (
	input  st_t                st,
	input  cfg_t               cfg,
	input  logic signed [32:0] disp,
	output ev_t                ev
);

	localparam int unsigned NMD = 7;
	localparam int unsigned SEL_W = $clog2(NMD);
	localparam int unsigned MD [NMD] = '{5, 10, 30, 60, 300, 600, 3600};

	localparam logic [31:0] U32   = 32'(UNITS_PER_SECOND);
	localparam logic [31:0] T15   = 32'(15 * UNITS_PER_SECOND);
	localparam logic [31:0] T30   = 32'(30 * UNITS_PER_SECOND);
	localparam logic [31:0] T60   = 32'(60 * UNITS_PER_SECOND);
	localparam logic [31:0] T300  = 32'(300 * UNITS_PER_SECOND);
	localparam logic [31:0] T600  = 32'(600 * UNITS_PER_SECOND);
	localparam logic [31:0] T3600 = 32'(3600 * UNITS_PER_SECOND);

	logic [33:0] m_tab  [NMD];
	logic [5:0]  sh_tab [NMD];

	// exact reciprocals of the mark periods for 32 bit dividends
	for (genvar gi = 0; gi < NMD; gi++) begin : g_recip
		localparam logic [63:0] CDIV = 64'(UNITS_PER_SECOND) * 64'(MD[gi]);
		localparam int unsigned LSH = $clog2(CDIV);
		localparam logic [63:0] MREC = ((64'd1 << (32 + LSH)) + CDIV - 64'd1) / CDIV;
		assign m_tab[gi]  = MREC[33:0];
		assign sh_tab[gi] = 6'(32 + LSH);
	end

	logic [31:0]      x;
	logic [31:0]      xu;
	logic             nonneg;
	logic [SEL_W-1:0] sel;
	logic [33:0]      m_sel;
	logic [5:0]       sh_sel;
	logic [65:0]      prod_a;
	logic [65:0]      prod_b;
	logic [65:0]      shr_a;
	logic [65:0]      shr_b;
	logic             on_mark;
	logic             le0;
	logic             ls_lt_prep;
	logic             ls_lt_one;
	logic signed [33:0] ls_s;

	assign x      = disp[31:0];
	assign nonneg = !disp[32];
	assign xu     = x - U32;

	always_comb begin
		if (x < T15)
			sel = SEL_W'(0);
		else if (x < T30)
			sel = SEL_W'(1);
		else if (x < T60)
			sel = SEL_W'(2);
		else if (x < T300)
			sel = SEL_W'(3);
		else if (x < T600)
			sel = SEL_W'(4);
		else if (x < T3600)
			sel = SEL_W'(5);
		else
			sel = SEL_W'(6);
	end

	assign m_sel  = m_tab[sel];
	assign sh_sel = sh_tab[sel];
	assign prod_a = {34'd0, x} * {32'd0, m_sel};
	assign prod_b = {34'd0, xu} * {32'd0, m_sel};
	assign shr_a  = prod_a >> sh_sel;
	assign shr_b  = prod_b >> sh_sel;

	// whole seconds on a multiple of the mark period: a period boundary lies in (x-u, x]
	assign on_mark = (x < U32) || (shr_a[31:0] != shr_b[31:0]);

	assign ls_s       = $signed({2'b00, st.last_signal});
	assign ls_lt_prep = ls_s < 34'(cfg_gap(cfg.start_gun, cfg.prep));
	assign ls_lt_one  = ls_s < 34'(cfg_gap(cfg.start_gun, cfg.one_min));

	always_comb begin
		ev = EV_NONE;
		if (st.mode == MODE_PRESET && nonneg)
			le0 = x < U32;
		else
			le0 = disp[32] || (disp == 33'sd0);
		if (st.last_signal < st.elapsed) begin
			case (st.mode)
				MODE_RACE: begin
					if (nonneg) begin
						if (x <= {12'd0, cfg.prep} && ls_lt_prep)
							ev = EV_MINOR;
						if (x <= {12'd0, cfg.one_min} && ls_lt_one)
							ev = EV_MINOR;
					end
				end
				MODE_PRESET: begin
					if (nonneg && on_mark)
						ev = EV_MINOR;
				end
				default: ;
			endcase
			if (le0 && st.last_signal < st.target)
				ev = EV_MAJOR;
		end
	end

endmodule

// ===== src/rcst_checker.sv =====
// port level checks for the race countdown stopwatch timer, bound to the top level
// depends on rcst_pkg
module rcst_checker import rcst_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [32:0]   time_shown,
	input logic [1:0]           event_res,
	input logic signed [32:0]   lap_time,
	input logic                 running,
	input logic [1:0]           mode_now,
	input logic                 fast_tick
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(time_shown) && $stable(lap_time))
		else $error("result changed while stalled");

	// fast tick hint only while running
	a_fast_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fast_tick |-> running)
		else $error("fast tick without running");

	// stopwatch display is the elapsed count, never negative
	a_sw_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_now == MODE_STOPWATCH |-> !time_shown[32])
		else $error("negative stopwatch display");

	// a major event means the countdown display has reached the gun
	a_major_disp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_MAJOR && mode_now == MODE_RACE
		|-> time_shown[32] || time_shown == 33'sd0)
		else $error("major event before the gun");

endmodule

bind race_countdown_stopwatch_timer rcst_checker u_rcst_checker (.*);

// ===== dv/race_countdown_stopwatch_timer_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for race_countdown_stopwatch_timer: directed timer commands,
// then random command traffic under several register settings with idle on both channels
// depends on rcst_pkg and the race_countdown_stopwatch_timer RTL
module race_countdown_stopwatch_timer_test;
	import rcst_pkg::*;

	localparam longint UPS = 10;
	localparam int unsigned MS_PER_UNIT = 1000 / 10;
	localparam longint FAST_LIMIT = UPS * 3600;
	localparam longint MAX_U32 = 64'hFFFF_FFFF;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned PHASE_ITEMS = 190;
	localparam logic [3:0] OP_UNUSED_LO = 4'd9;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;
	localparam logic [15:0] TICK_FAST_MS = 16'd100;
	localparam logic [15:0] TICK_SLOW_MS = 16'd1000;
	localparam logic [39:0] WALL_MAX = '1;
	localparam logic signed [32:0] VALUE_MIN = {1'b1, 32'b0};
	localparam logic signed [32:0] VALUE_MAX = {1'b0, {32{1'b1}}};
	localparam logic [CFG_W-1:0] CFG_MAX = 20'd1000000;

	typedef struct packed {
		logic signed [32:0] shown;
		ev_t                ev;
		logic signed [32:0] lap;
		logic               run;
		mode_t              mode;
		logic               fast;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_ready;
	logic [3:0] opcode;
	logic [15:0] tick_ms;
	logic [39:0] wall_time;
	logic [1:0] new_mode;
	logic signed [32:0] value;
	logic out_valid;
	logic out_ready;
	logic signed [32:0] time_shown;
	logic [1:0] event_res;
	logic signed [32:0] lap_time;
	logic running;
	logic [1:0] mode_now;
	logic fast_tick;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// timer state as predicted
	logic [CFG_W-1:0] cfg_gun, cfg_prep, cfg_one_min, cfg_lap_sw;
	logic [31:0] elapsed, target, preset, last_lap, last_signal;
	logic [39:0] origin, last_wall;
	logic is_running;
	mode_t mode;

	timer_result_t pending_results[$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit no_stall = 1'b0;
	logic [39:0] wall_clock = '0;

	race_countdown_stopwatch_timer #(.UNITS_PER_SECOND(10)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.tick_ms(tick_ms),
		.wall_time(wall_time),
		.new_mode(new_mode),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.time_shown(time_shown),
		.event_res(event_res),
		.lap_time(lap_time),
		.running(running),
		.mode_now(mode_now),
		.fast_tick(fast_tick),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic void reset_timer_model();
		cfg_gun = START_GUN_RST;
		cfg_prep = PREP_RST;
		cfg_one_min = ONE_MIN_RST;
		cfg_lap_sw = LAP_SW_RST;
		elapsed = '0;
		is_running = 1'b0;
		origin = '0;
		last_wall = '0;
		target = {12'b0, START_GUN_RST};
		preset = 32'(UPS * 600);
		mode = MODE_RACE;
		last_lap = '0;
		last_signal = '0;
	endfunction

	function automatic longint shown_time();
		longint el, tg;
		el = elapsed;
		tg = target;
		if (mode == MODE_STOPWATCH)
			return el;
		return tg - el;
	endfunction

	// negative values are dropped, nonzero ones only land while running
	function automatic void jump_elapsed(longint v);
		if (v < 0)
			return;
		if (!(is_running || v == 0))
			return;
		elapsed = v[31:0];
		last_signal = elapsed;
		origin = last_wall - {8'b0, elapsed};
		last_lap = elapsed;
	endfunction

	function automatic ev_t timer_event();
		longint d, ls, g, pr, om, tg, step;
		ev_t ev;
		ev = EV_NONE;
		d = shown_time();
		ls = last_signal;
		g = cfg_gun;
		pr = cfg_prep;
		om = cfg_one_min;
		tg = target;
		if (last_signal >= elapsed)
			return EV_NONE;
		if (mode == MODE_RACE) begin
			if (d >= 0) begin
				if (d <= pr && ls < g - pr)
					ev = EV_MINOR;
				if (d <= om && ls < g - om)
					ev = EV_MINOR;
			end
		end else if (mode == MODE_PRESET) begin
			if (d >= 0) begin
				step = UPS * 3600;
				if (d < UPS * 3600) step = UPS * 600;
				if (d < UPS * 600) step = UPS * 300;
				if (d < UPS * 300) step = UPS * 60;
				if (d < UPS * 60) step = UPS * 30;
				if (d < UPS * 30) step = UPS * 10;
				if (d < UPS * 15) step = UPS * 5;
				// whole seconds only, so under one second reads as zero
				step = step / UPS;
				d = d / UPS;
				if (d % step == 0)
					ev = EV_MINOR;
			end
		end
		if (d <= 0 && ls < tg)
			ev = EV_MAJOR;
		return ev;
	endfunction

	function automatic timer_result_t run_command(logic [3:0] op, logic [15:0] tms,
			logic [39:0] wt, logic [1:0] nm, logic signed [32:0] val);
		timer_result_t r;
		longint v, lap_val, el, tg, ll, g, pr, om, sw, sat, shown;
		logic [39:0] span;
		v = val;
		lap_val = 0;
		el = elapsed;
		tg = target;
		ll = last_lap;
		g = cfg_gun;
		pr = cfg_prep;
		om = cfg_one_min;
		sw = cfg_lap_sw;
		r.ev = EV_NONE;
		case (op)
			OP_TICK: if (is_running) begin
				if (last_wall == '0)
					last_wall = wt;
				elapsed = elapsed + tms / MS_PER_UNIT;
				if (wt > last_wall) begin
					if (origin == '0) begin
						origin = wt - {8'b0, elapsed};
					end else begin
						span = wt - origin;
						elapsed = span[31:0];
					end
				end
				last_wall = wt;
			end
			OP_START: begin
				is_running = 1'b1;
				last_wall = '0;
				origin = '0;
			end
			OP_STOP: is_running = 1'b0;
			OP_RESET: jump_elapsed(0);
			OP_LAP: begin
				if (mode == MODE_STOPWATCH) begin
					lap_val = el - ll;
					last_lap = elapsed;
				end else if (mode == MODE_RACE || mode == MODE_PRESET) begin
					lap_val = tg - el;
					last_lap = elapsed;
					if (mode == MODE_RACE) begin
						if (lap_val >= sw)
							jump_elapsed(g - pr);
						else
							jump_elapsed(g - om);
					end
				end
			end
			OP_MODE: begin
				mode = mode_t'(nm);
				if (mode == MODE_RACE)
					target = {12'b0, cfg_gun};
				else if (mode == MODE_PRESET)
					target = preset;
			end
			OP_EVENT: begin
				r.ev = timer_event();
				if (r.ev != EV_NONE) begin
					sat = el + UPS;
					last_signal = (sat > MAX_U32) ? 32'hFFFF_FFFF : sat[31:0];
				end
			end
			OP_ELAPSED: jump_elapsed(v);
			OP_PRESET: begin
				if (v > 0)
					preset = v[31:0];
				if (mode == MODE_PRESET)
					target = preset;
				last_signal = '0;
			end
			default: ;
		endcase
		shown = shown_time();
		el = elapsed;
		r.shown = shown[32:0];
		r.lap = lap_val[32:0];
		r.run = is_running;
		r.mode = mode;
		r.fast = is_running && el <= FAST_LIMIT;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [32:0] want, logic [32:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			fail_count = fail_count + 1;
		end
	endfunction

	always @(posedge clk) begin : result_check
		timer_result_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, time_shown expected none got %0h",
					$time, time_shown);
				fail_count = fail_count + 1;
			end else begin
				want = pending_results.pop_front();
				compare_field("time_shown", want.shown, time_shown);
				compare_field("event_res", 33'(want.ev), 33'(event_res));
				compare_field("lap_time", want.lap, lap_time);
				compare_field("running", 33'(want.run), 33'(running));
				compare_field("mode_now", 33'(want.mode), 33'(mode_now));
				compare_field("fast_tick", 33'(want.fast), 33'(fast_tick));
			end
		end
	end

	// result side: random stall before each transfer
	initial begin : result_sink
		int unsigned gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = no_stall ? 0 : $urandom_range(0, 9);
			if (gap != 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
		end
	end

	task automatic send_cmd(input logic [3:0] op, input logic [15:0] tms, input logic [39:0] wt,
			input logic [1:0] nm, input logic signed [32:0] val);
		int unsigned gap;
		gap = no_stall ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		tick_ms <= tms;
		wall_time <= wt;
		new_mode <= nm;
		value <= val;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_results.push_back(run_command(op, tms, wt, nm, val));
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_START_GUN: cfg_gun = data;
			CFG_PREP: cfg_prep = data;
			CFG_ONE_MIN: cfg_one_min = data;
			CFG_LAP_SW: cfg_lap_sw = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_config(input logic [CFG_W-1:0] gun, prep, one_min, lap_sw);
		write_register(CFG_START_GUN, gun);
		write_register(CFG_PREP, prep);
		write_register(CFG_ONE_MIN, one_min);
		write_register(CFG_LAP_SW, lap_sw);
	endtask

	task automatic test_stopped_commands();
		send_cmd(OP_EVENT, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_LAP, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_ELAPSED, '0, '0, MODE_STOPWATCH, 33'sd1234);
		send_cmd(OP_ELAPSED, '0, '0, MODE_STOPWATCH, VALUE_MIN);
		send_cmd(OP_UNUSED_HI, '1, WALL_MAX, MODE_WATCH, VALUE_MAX);
	endtask

	task automatic test_race_signals();
		send_cmd(OP_START, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_TICK, '1, WALL_MAX, MODE_STOPWATCH, '0);
		send_cmd(OP_TICK, '0, '0, MODE_STOPWATCH, '0);
		// preparatory signal, then the guard against a repeat
		send_cmd(OP_ELAPSED, '0, '0, MODE_STOPWATCH, 33'sd599);
		send_cmd(OP_TICK, TICK_FAST_MS, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_EVENT, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_EVENT, '0, '0, MODE_STOPWATCH, '0);
		// lap below the switch time goes to the one-minute signal
		send_cmd(OP_ELAPSED, '0, '0, MODE_STOPWATCH, 33'sd2399);
		send_cmd(OP_LAP, '0, '0, MODE_STOPWATCH, '0);
		// gun
		send_cmd(OP_ELAPSED, '0, '0, MODE_STOPWATCH, 33'sd2999);
		send_cmd(OP_TICK, TICK_FAST_MS, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_EVENT, '0, '0, MODE_STOPWATCH, '0);
	endtask

	task automatic test_preset_and_modes();
		send_cmd(OP_MODE, '0, '0, MODE_PRESET, '0);
		send_cmd(OP_PRESET, '0, '0, MODE_STOPWATCH, 33'sd100);
		// under one second left counts as zero
		send_cmd(OP_ELAPSED, '0, '0, MODE_STOPWATCH, 33'sd95);
		send_cmd(OP_TICK, TICK_FAST_MS, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_EVENT, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_MODE, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_LAP, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_MODE, '0, '0, MODE_WATCH, '0);
		send_cmd(OP_LAP, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_PRESET, '0, '0, MODE_STOPWATCH, VALUE_MIN);
		send_cmd(OP_PRESET, '0, '0, MODE_STOPWATCH, VALUE_MAX);
		send_cmd(OP_STOP, '0, '0, MODE_STOPWATCH, '0);
	endtask

	// preparatory signal longer than the countdown: the lap jump would go negative
	task automatic test_negative_jump();
		settle();
		load_config(20'd100, CFG_MAX, 20'd1, 20'd50);
		send_cmd(OP_MODE, '0, '0, MODE_RACE, '0);
		send_cmd(OP_START, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_RESET, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_LAP, '0, '0, MODE_STOPWATCH, '0);
		send_cmd(OP_ELAPSED, '0, '0, MODE_STOPWATCH, 33'sd80);
		send_cmd(OP_LAP, '0, '0, MODE_STOPWATCH, '0);
	endtask

	task automatic random_commands(input int unsigned count);
		logic [3:0] op;
		logic [15:0] tms;
		logic [1:0] nm;
		logic signed [32:0] val;
		longint base, g, p, o;
		int unsigned pick, i;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 0)
				no_stall = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 35) op = OP_TICK;
			else if (pick < 60) op = OP_EVENT;
			else if (pick < 68) op = OP_LAP;
			else if (pick < 73) op = OP_START;
			else if (pick < 77) op = OP_STOP;
			else if (pick < 80) op = OP_RESET;
			else if (pick < 87) op = OP_MODE;
			else if (pick < 94) op = OP_ELAPSED;
			else if (pick < 98) op = OP_PRESET;
			else op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: tms = TICK_FAST_MS;
				5, 6, 7: tms = TICK_SLOW_MS;
				8: tms = 16'($urandom_range(0, 16'hFFFF));
				default: tms = '0;
			endcase

			// wall clock mostly follows the tick length
			if (op == OP_TICK) begin
				pick = $urandom_range(0, 49);
				if (pick == 0)
					wall_clock = '0;
				else if (pick == 1)
					wall_clock = 40'({$urandom, $urandom});
				else if (pick == 2)
					wall_clock = wall_clock - 40'($urandom_range(1, 50));
				else if (pick > 8)
					wall_clock = wall_clock + tms / MS_PER_UNIT;
			end

			// values mostly just short of a signal time
			g = cfg_gun;
			p = cfg_prep;
			o = cfg_one_min;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					case ($urandom_range(0, 3))
						0: base = g - p;
						1: base = g - o;
						2: base = g;
						default: base = preset;
					endcase
					pick = $urandom_range(0, 20);
					base = base - pick;
					val = base[32:0];
				end
				6, 7: val = 33'($urandom_range(0, 100));
				8: begin
					base = $urandom_range(1, 1000);
					base = -base;
					val = base[32:0];
				end
				default: val = 33'({$urandom, $urandom});
			endcase
			if (op == OP_PRESET) begin
				pick = $urandom_range(0, 7);
				if (pick < 6)
					val = 33'($urandom_range(1, 600));
				else if (pick == 6)
					val = '0;
			end
			nm = 2'($urandom_range(0, 3));
			send_cmd(op, tms, wall_clock, nm, val);
		end
		no_stall = 1'b0;
	endtask

	task automatic test_random_traffic();
		int unsigned phase;
		for (phase = 0; phase < 7; phase++) begin
			settle();
			case (phase)
				0: load_config(20'd300, 20'd240, 20'd60, 20'd120);
				1: load_config(START_GUN_RST, PREP_RST, ONE_MIN_RST, LAP_SW_RST);
				2: load_config(CFG_MAX, 20'd1, CFG_MAX, 20'd1);
				3: load_config(20'd1, 20'd1, 20'd1, 20'd1);
				4: load_config(20'd1, CFG_MAX, 20'd1, CFG_MAX);
				default: load_config(CFG_W'($urandom_range(1, CFG_MAX)),
					CFG_W'($urandom_range(1, CFG_MAX)),
					CFG_W'($urandom_range(1, CFG_MAX)),
					CFG_W'($urandom_range(1, CFG_MAX)));
			endcase
			random_commands(PHASE_ITEMS);
		end
	endtask

	initial begin
		in_valid = 1'b0;
		opcode = OP_TICK;
		tick_ms = '0;
		wall_time = '0;
		new_mode = MODE_STOPWATCH;
		value = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_START_GUN;
		cfg_data = '0;
		reset_timer_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_stopped_commands();
		test_race_signals();
		test_preset_and_modes();
		test_negative_jump();
		test_random_traffic();
		settle();

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/rcst_pkg.sv
src/rcst_event.sv
src/race_countdown_stopwatch_timer.sv
src/rcst_checker.sv
dv/race_countdown_stopwatch_timer_test.sv
